// ===== rtl/rar_pkg.sv =====
// Shared constants, action codes and controller/datapath interface types.
package rar_pkg;

  localparam int OPERAND_WIDTH_DEFAULT = 16;
  localparam int ACTION_WIDTH          = 2;
  localparam int NUM_OUT_WIDTH         = 33;
  localparam int DEN_OUT_WIDTH         = 32;
  localparam int WRAP_WIDTH            = 64;

  localparam logic [ACTION_WIDTH-1:0] ACT_ADD = 2'd0;
  localparam logic [ACTION_WIDTH-1:0] ACT_SUB = 2'd1;
  localparam logic [ACTION_WIDTH-1:0] ACT_MUL = 2'd2;
  localparam logic [ACTION_WIDTH-1:0] ACT_DIV = 2'd3;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       sum_en;
    logic       mag_en;
    logic       gcd_en;
    logic       scale_en;
    logic       div_en;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic skip;
  } status_t;

endpackage

// ===== rtl/rational_arithmetic_reducer.sv =====
// Top level of the rational arithmetic reducer: controller plus datapath.
//
// This block combines two signed fractions a/b and c/d with add, subtract,
// multiply or divide and returns the result reduced by the gcd of the
// magnitudes of its numerator and denominator, with signs kept as computed.
// A zero denominator raises zero_denominator and the fraction comes back
// unreduced; a zero numerator also comes back unreduced. One item is worked
// at a time. With W = OPERAND_WIDTH, an item passes through capture, three
// products through one shared W by W multiplier, the sum and the magnitude
// step, then binary gcd (one shift or subtract a cycle), a scaling step,
// the pair of restoring dividers and the load into the output register; when
// reduction is skipped, the gcd step leads straight to the output register.
// The result sits in an output register, so the next transfer is taken while
// a finished result still waits on out_stall. Results wider than the output
// fields, possible only at larger operand widths, wrap to the field width.
module rational_arithmetic_reducer #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [rar_pkg::ACTION_WIDTH-1:0]         action,
  input  logic signed [OPERAND_WIDTH-1:0]          first_numerator,
  input  logic signed [OPERAND_WIDTH-1:0]          first_denominator,
  input  logic signed [OPERAND_WIDTH-1:0]          second_numerator,
  input  logic signed [OPERAND_WIDTH-1:0]          second_denominator,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [rar_pkg::NUM_OUT_WIDTH-1:0] result_numerator,
  output logic signed [rar_pkg::DEN_OUT_WIDTH-1:0] result_denominator,
  output logic                                     zero_denominator
);

  // Commands flow from the sequencer to the datapath, status flows back.
  rar_pkg::cmd_t    cmd;
  rar_pkg::status_t status;

  rar_controller #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rar_datapath #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .cmd                (cmd),
    .status             (status),
    .action             (action),
    .first_numerator    (first_numerator),
    .first_denominator  (first_denominator),
    .second_numerator   (second_numerator),
    .second_denominator (second_denominator),
    .result_numerator   (result_numerator),
    .result_denominator (result_denominator),
    .zero_denominator   (zero_denominator)
  );

endmodule

// ===== rtl/rar_controller.sv =====
// Sequencer that steps the datapath through multiply, gcd and divide phases.
module rar_controller #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  rar_pkg::status_t status,
  output rar_pkg::cmd_t    cmd
);

  localparam int MW = 2 * OPERAND_WIDTH;
  localparam int CW = $clog2(MW);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUM, S_MAG, S_GCD, S_SCALE, S_DIV, S_FINISH
  } state_t;

  state_t        state;
  logic [1:0]    step;
  logic [CW-1:0] cnt;
  logic          out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.mul_step = step;
    case (state)
      S_IDLE:   cmd.load     = in_valid;
      S_MUL:    cmd.mul_en   = 1'b1;
      S_SUM:    cmd.sum_en   = 1'b1;
      S_MAG:    cmd.mag_en   = 1'b1;
      S_GCD:    cmd.gcd_en   = !status.skip && !status.gcd_done;
      S_SCALE:  cmd.scale_en = 1'b1;
      S_DIV:    cmd.div_en   = 1'b1;
      S_FINISH: cmd.out_load = out_free;
      default:  cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          step <= '0;
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (step == 2'd2) begin
            step  <= '0;
            state <= S_SUM;
          end else begin
            step <= step + 2'd1;
          end
        end
        S_SUM: state <= S_MAG;
        S_MAG: state <= S_GCD;
        S_GCD: begin
          if (status.skip) begin
            state <= S_FINISH;
          end else if (status.gcd_done) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == CW'(MW - 1)) begin
            state <= S_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rar_datapath.sv =====
// Operand registers, shared multiplier, binary gcd and two restoring dividers.
module rar_datapath #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEFAULT
) (
  input  logic                                    clk,
  input  rar_pkg::cmd_t                           cmd,
  output rar_pkg::status_t                        status,
  input  logic [rar_pkg::ACTION_WIDTH-1:0]        action,
  input  logic signed [OPERAND_WIDTH-1:0]         first_numerator,
  input  logic signed [OPERAND_WIDTH-1:0]         first_denominator,
  input  logic signed [OPERAND_WIDTH-1:0]         second_numerator,
  input  logic signed [OPERAND_WIDTH-1:0]         second_denominator,
  output logic signed [rar_pkg::NUM_OUT_WIDTH-1:0] result_numerator,
  output logic signed [rar_pkg::DEN_OUT_WIDTH-1:0] result_denominator,
  output logic                                    zero_denominator
);

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int MW = 2 * W;
  localparam int KW = $clog2(MW);
  localparam int XW = rar_pkg::WRAP_WIDTH;

  logic [rar_pkg::ACTION_WIDTH-1:0] op;
  logic signed [W-1:0]  a, b, c, d;
  logic signed [PW-1:0] p0, p1, p2;
  logic signed [SW-1:0] num;
  logic signed [PW-1:0] den;
  logic                 neg_num, neg_den, zero_num, zero_den;
  logic [MW-1:0]        u, v, g;
  logic [KW-1:0]        k;
  logic [MW-1:0]        qn, qd, rn, rd;

  logic signed [W-1:0]  mul_x, mul_y;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] num_abs;
  logic signed [PW-1:0] den_abs;
  logic [MW:0]          trial_n, trial_d;
  logic                 fit_n, fit_d;
  logic signed [SW-1:0] num_red, num_sel;
  logic signed [PW-1:0] den_red, den_sel;
  logic signed [XW-1:0] num_wide, den_wide;

  assign status.gcd_done = (u == v);
  assign status.skip     = zero_num || zero_den;

  // Operand pairs for the three multiply steps, chosen by action.
  always_comb begin
    case (cmd.mul_step)
      2'd0: begin
        mul_x = a;
        mul_y = (op == rar_pkg::ACT_MUL) ? c : d;
      end
      2'd1: begin
        mul_x = b;
        mul_y = (op == rar_pkg::ACT_ADD || op == rar_pkg::ACT_SUB) ? c : '0;
      end
      default: begin
        mul_x = b;
        mul_y = (op == rar_pkg::ACT_DIV) ? c : d;
      end
    endcase
  end

  assign prod    = PW'(mul_x) * PW'(mul_y);
  assign num_abs = num[SW-1] ? -num : num;
  assign den_abs = den[PW-1] ? -den : den;

  assign trial_n = {rn, qn[MW-1]};
  assign trial_d = {rd, qd[MW-1]};
  assign fit_n   = (trial_n >= {1'b0, g});
  assign fit_d   = (trial_d >= {1'b0, g});

  assign num_red  = neg_num ? -$signed(SW'(qn)) : $signed(SW'(qn));
  assign den_red  = neg_den ? -$signed(PW'(qd)) : $signed(PW'(qd));
  assign num_sel  = status.skip ? num : num_red;
  assign den_sel  = status.skip ? den : den_red;
  assign num_wide = XW'(num_sel);
  assign den_wide = XW'(den_sel);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= action;
      a  <= first_numerator;
      b  <= first_denominator;
      c  <= second_numerator;
      d  <= second_denominator;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_step)
        2'd0:    p0 <= prod;
        2'd1:    p1 <= prod;
        default: p2 <= prod;
      endcase
    end
    if (cmd.sum_en) begin
      num <= (op == rar_pkg::ACT_SUB) ? SW'(p0) - SW'(p1) : SW'(p0) + SW'(p1);
      den <= p2;
    end
    if (cmd.mag_en) begin
      neg_num  <= num[SW-1];
      neg_den  <= den[PW-1];
      zero_num <= (num == '0);
      zero_den <= (den == '0);
      u        <= MW'(num_abs);
      v        <= MW'(den_abs);
      k        <= '0;
    end
    // Binary gcd: strip common factors of two, then subtract odd from odd.
    if (cmd.gcd_en) begin
      if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + 1'b1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u > v) begin
        u <= (u - v) >> 1;
      end else begin
        v <= (v - u) >> 1;
      end
    end
    if (cmd.scale_en) begin
      g  <= u << k;
      qn <= u << k == '0 ? '0 : MW'(num_abs);
      qd <= MW'(den_abs);
      rn <= '0;
      rd <= '0;
    end
    // Both magnitudes are divided by the gcd in parallel, one bit a cycle.
    if (cmd.div_en) begin
      rn <= fit_n ? MW'(trial_n - {1'b0, g}) : trial_n[MW-1:0];
      rd <= fit_d ? MW'(trial_d - {1'b0, g}) : trial_d[MW-1:0];
      qn <= {qn[MW-2:0], fit_n};
      qd <= {qd[MW-2:0], fit_d};
    end
    if (cmd.out_load) begin
      result_numerator   <= num_wide[rar_pkg::NUM_OUT_WIDTH-1:0];
      result_denominator <= den_wide[rar_pkg::DEN_OUT_WIDTH-1:0];
      zero_denominator   <= zero_den;
    end
  end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the rational arithmetic reducer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block runs at its default operand width throughout.
  localparam int OPW          = rar_pkg::OPERAND_WIDTH_DEFAULT;
  localparam int RANDOM_ITEMS = 950;
  localparam int SETTLE_TAIL  = 120;

  // One reduced fraction as the block returns it.
  typedef struct packed {
    logic signed [rar_pkg::NUM_OUT_WIDTH-1:0] num;
    logic signed [rar_pkg::DEN_OUT_WIDTH-1:0] den;
    logic                                     zero;
  } fraction_t;

  // One stimulus row. Where known is set, the expected fraction is typed in
  // the row itself; otherwise the predictor supplies it.
  typedef struct {
    logic [rar_pkg::ACTION_WIDTH-1:0] op;
    int                               a;
    int                               b;
    int                               c;
    int                               d;
    bit                               known;
    longint                           num;
    longint                           den;
    bit                               zero;
  } operand_row_t;

  // Directed part: extremes of every operand, every action, zero
  // denominators, zero numerators and negative denominators.
  localparam int NUM_DIRECTED = 20;
  operand_row_t directed_rows [NUM_DIRECTED] = '{
    '{rar_pkg::ACT_ADD,      0,      1,      0,      1, 1,      0,  1, 0},
    '{rar_pkg::ACT_ADD,      1,      0,      1,      1, 1,      1,  0, 1},
    '{rar_pkg::ACT_MUL,      0,      0,      0,      0, 1,      0,  0, 1},
    '{rar_pkg::ACT_DIV,      2,      3,      0,      5, 1,     10,  0, 1},
    '{rar_pkg::ACT_MUL,      0,      5,      3,      7, 1,      0, 35, 0},
    '{rar_pkg::ACT_SUB,      5,      3,      5,      3, 1,      0,  9, 0},
    '{rar_pkg::ACT_ADD,      1,      1,      1,      1, 1,      2,  1, 0},
    '{rar_pkg::ACT_MUL,      1,     -2,      1,      1, 1,      1, -2, 0},
    '{rar_pkg::ACT_MUL, -32768, -32768, -32768, -32768, 1,      1,  1, 0},
    '{rar_pkg::ACT_ADD, -32768,      1, -32768,      1, 1, -65536,  1, 0},
    '{rar_pkg::ACT_ADD,  32767,  32767,  32767,  32767, 1,      2,  1, 0},
    '{rar_pkg::ACT_DIV,     -1,     -1,     -1,     -1, 1,      1,  1, 0},
    '{rar_pkg::ACT_ADD,  32767,      1,  32767,      1, 1,  65534,  1, 0},
    '{rar_pkg::ACT_SUB, -32768,      1,  32767,      1, 1, -65535,  1, 0},
    '{rar_pkg::ACT_SUB, -32768,  32767,  32767, -32768, 0,      0,  0, 0},
    '{rar_pkg::ACT_DIV,  32767, -32768, -32768,  32767, 0,      0,  0, 0},
    '{rar_pkg::ACT_ADD,  32767, -32768,  32767, -32768, 0,      0,  0, 0},
    '{rar_pkg::ACT_MUL, -32768,  32767, -32768,  32767, 0,      0,  0, 0},
    '{rar_pkg::ACT_SUB,      3,      4,     -5,      6, 0,      0,  0, 0},
    '{rar_pkg::ACT_DIV,      6,     -4,     -9,     10, 0,      0,  0, 0}
  };

  localparam int TOTAL_ITEMS = NUM_DIRECTED + RANDOM_ITEMS;

  logic                                     clk                = 1'b0;
  logic                                     rst                = 1'b1;
  logic                                     in_valid           = 1'b0;
  logic                                     in_stall;
  logic [rar_pkg::ACTION_WIDTH-1:0]         action             = rar_pkg::ACT_ADD;
  logic signed [OPW-1:0]                    first_numerator    = '0;
  logic signed [OPW-1:0]                    first_denominator  = '0;
  logic signed [OPW-1:0]                    second_numerator   = '0;
  logic signed [OPW-1:0]                    second_denominator = '0;
  logic                                     out_valid;
  logic                                     out_stall          = 1'b0;
  logic signed [rar_pkg::NUM_OUT_WIDTH-1:0] result_numerator;
  logic signed [rar_pkg::DEN_OUT_WIDTH-1:0] result_denominator;
  logic                                     zero_denominator;

  // Fractions still owed by the block, oldest first.
  fraction_t    owed_fractions [$];
  operand_row_t held_row;
  int           items_sent     = 0;
  int           mismatch_count = 0;
  int           sender_idle_pct;
  int           receiver_idle_pct;

  rational_arithmetic_reducer #(
    .OPERAND_WIDTH(OPW)
  ) u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .action            (action),
    .first_numerator   (first_numerator),
    .first_denominator (first_denominator),
    .second_numerator  (second_numerator),
    .second_denominator(second_denominator),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .result_numerator  (result_numerator),
    .result_denominator(result_denominator),
    .zero_denominator  (zero_denominator)
  );

  always #6 clk = ~clk;

  // Computes the fraction the block must return for one item. The operands
  // are sign-extended into 64-bit integers, which hold every intermediate
  // exactly. Reduction is by the gcd of the magnitudes, so a negative
  // denominator keeps its sign; zero parts skip reduction entirely.
  function automatic fraction_t reduce_fraction(input operand_row_t row);
    longint            a, b, c, d, num, den;
    longint unsigned   x, y, t;
    fraction_t         f;
    logic signed [OPW-1:0] a_w, b_w, c_w, d_w;
    a_w = row.a[OPW-1:0];
    b_w = row.b[OPW-1:0];
    c_w = row.c[OPW-1:0];
    d_w = row.d[OPW-1:0];
    a = a_w;
    b = b_w;
    c = c_w;
    d = d_w;
    case (row.op)
      rar_pkg::ACT_ADD: begin
        num = a * d + b * c;
        den = b * d;
      end
      rar_pkg::ACT_SUB: begin
        num = a * d - b * c;
        den = b * d;
      end
      rar_pkg::ACT_MUL: begin
        num = a * c;
        den = b * d;
      end
      default: begin
        num = a * d;
        den = c * b;
      end
    endcase
    f.zero = (den == 0);
    if (!f.zero && num != 0) begin
      x = (num < 0) ? -num : num;
      y = (den < 0) ? -den : den;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      num = num / longint'(x);
      den = den / longint'(x);
    end
    f.num = num[rar_pkg::NUM_OUT_WIDTH-1:0];
    f.den = den[rar_pkg::DEN_OUT_WIDTH-1:0];
    return f;
  endfunction

  // Draws one operand. Full-range values exercise every bit, small values
  // and scaled powers of two give nontrivial common factors, and a few
  // zeros and extremes keep the special cases coming.
  function automatic int draw_operand();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return $urandom_range(65535) - 32768;
    if (pick < 72) return $urandom_range(40) - 20;
    if (pick < 86) return ($urandom_range(255) - 128) * (1 << $urandom_range(7));
    if (pick < 92) return 0;
    case ($urandom_range(3))
      0:       return -32768;
      1:       return 32767;
      2:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic operand_row_t next_row(input int idx);
    operand_row_t row;
    if (idx < NUM_DIRECTED) return directed_rows[idx];
    row.op    = rar_pkg::ACTION_WIDTH'($urandom_range(3));
    row.a     = draw_operand();
    row.b     = draw_operand();
    row.c     = draw_operand();
    row.d     = draw_operand();
    row.known = 1'b0;
    row.num   = 0;
    row.den   = 0;
    row.zero  = 1'b0;
    return row;
  endfunction

  // Idling moves through three phases as the stimulus advances: first the
  // sender idles lightly and the receiver heavily, then the reverse, and in
  // the last third neither side idles at all.
  always_comb begin
    if (items_sent < TOTAL_ITEMS / 3) begin
      sender_idle_pct   = 22;
      receiver_idle_pct = 52;
    end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
      sender_idle_pct   = 52;
      receiver_idle_pct = 22;
    end else begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end
  end

  // Input side. A transfer takes place at an edge where in_valid is high and
  // in_stall is low; the expectation for that item is recorded right there.
  // A new item is offered only once the held one has transferred, so the
  // payload stays put while stalled and in_valid never looks at in_stall.
  always @(posedge clk) begin
    fraction_t    owed;
    bit           moved;
    operand_row_t row;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      moved = in_valid && !in_stall;
      if (moved) begin
        if (held_row.known) begin
          owed.num  = held_row.num[rar_pkg::NUM_OUT_WIDTH-1:0];
          owed.den  = held_row.den[rar_pkg::DEN_OUT_WIDTH-1:0];
          owed.zero = held_row.zero;
        end else begin
          owed = reduce_fraction(held_row);
        end
        owed_fractions.push_back(owed);
        items_sent = items_sent + 1;
      end
      if (!in_valid || moved) begin
        if (items_sent < TOTAL_ITEMS && $urandom_range(99) >= sender_idle_pct) begin
          row                = next_row(items_sent);
          held_row           = row;
          action             <= row.op;
          first_numerator    <= row.a[OPW-1:0];
          first_denominator  <= row.b[OPW-1:0];
          second_numerator   <= row.c[OPW-1:0];
          second_denominator <= row.d[OPW-1:0];
          in_valid           <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side. Every result transfer is checked field by field against the
  // oldest owed fraction, and out_stall is redrawn on every edge.
  always @(posedge clk) begin
    fraction_t owed;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_fractions.size() == 0) begin
          $error("result transfer with nothing owed: %0d/%0d zero_denominator=%0b",
                 result_numerator, result_denominator, zero_denominator);
          mismatch_count = mismatch_count + 1;
        end else begin
          owed = owed_fractions.pop_front();
          if (result_numerator !== owed.num) begin
            $error("result_numerator: expected %0d, got %0d", owed.num, result_numerator);
            mismatch_count = mismatch_count + 1;
          end
          if (result_denominator !== owed.den) begin
            $error("result_denominator: expected %0d, got %0d",
                   owed.den, result_denominator);
            mismatch_count = mismatch_count + 1;
          end
          if (zero_denominator !== owed.zero) begin
            $error("zero_denominator: expected %0b, got %0b", owed.zero, zero_denominator);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // Hold reset, let the stimulus run out, wait for every owed fraction, then
  // watch a while longer for stray results before deciding.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (items_sent < TOTAL_ITEMS || owed_fractions.size() != 0) @(posedge clk);
    repeat (SETTLE_TAIL) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop in case the block hangs; a correct run ends far sooner.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rar_pkg.sv
rtl/rar_controller.sv
rtl/rar_datapath.sv
rtl/rational_arithmetic_reducer.sv
tb/tb.sv
